// ----- design/ppl_pkg.sv -----
// shared types and constants for the positional pair list
// no dependencies; imported by ppl_ctrl, ppl_datapath and positional_pair_list
`default_nettype none

package ppl_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 5;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_DECIDE,
      STATE_REMOVE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic reject;
      logic arm_remove;
      logic remove_step;
   } ctrl_cmd_type;

   typedef struct packed {
      status_type verdict;
      logic       remove_op;
      logic       final_step;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- design/ppl_ctrl.sv -----
// controller state machine for the positional pair list
// depends on ppl_pkg; drives commands into ppl_datapath
`default_nettype none

module ppl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire ppl_pkg::dp_stat_type  stat,
   output      ppl_pkg::ctrl_cmd_type cmd
);
   import ppl_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         STATE_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = STATE_DECIDE;
            end
         end
         STATE_DECIDE: begin
            if (stat.verdict != STATUS_DONE) begin
               cmd.reject = 1'b1;
               state_in   = STATE_IDLE;
            end else if (stat.remove_op) begin
               cmd.arm_remove = 1'b1;
               state_in       = STATE_REMOVE;
            end else begin
               cmd.commit = 1'b1;
               state_in   = STATE_IDLE;
            end
         end
         STATE_REMOVE: begin
            cmd.remove_step = 1'b1;
            if (stat.final_step) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != STATE_IDLE);

endmodule

`default_nettype wire

// ----- design/ppl_datapath.sv -----
// shift-array storage, request checks and result registers
// depends on ppl_pkg; commanded by ppl_ctrl
`default_nettype none

module ppl_datapath #(
   parameter int CAPACITY   = ppl_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = ppl_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppl_pkg::ctrl_cmd_type         cmd,
   output      ppl_pkg::dp_stat_type          stat,
   input  wire logic [ppl_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [ppl_pkg::VALUE_W-1:0]   req_first_value,
   input  wire logic [ppl_pkg::VALUE_W-1:0]   req_second_value,
   input  wire logic [ppl_pkg::INDEX_W-1:0]   req_position,
   input  wire logic [ppl_pkg::INDEX_W-1:0]   req_range_end,
   output      logic                          rsp_valid,
   output      logic [ppl_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [ppl_pkg::VALUE_W-1:0]   rsp_removed_first,
   output      logic [ppl_pkg::VALUE_W-1:0]   rsp_removed_second,
   output      logic [ppl_pkg::TOTAL_W-1:0]   rsp_entry_total,
   output      logic                          rsp_last
);
   import ppl_pkg::*;

   localparam int StoreWidth = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CountWidth = $clog2(CAPACITY + 1);
   localparam int IdxWidth   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CmpWidth   = ((CountWidth > INDEX_W) ? CountWidth : INDEX_W) + 1;
   localparam logic [CmpWidth-1:0] CapLimit = CmpWidth'(CAPACITY);

   logic [OPCODE_W-1:0]   op_ff;
   logic [StoreWidth-1:0] first_in_ff;
   logic [StoreWidth-1:0] second_in_ff;
   logic [INDEX_W-1:0]    pos_ff;
   logic [INDEX_W-1:0]    end_ff;
   logic [INDEX_W-1:0]    remain_ff;
   logic [CountWidth-1:0] count_ff;

   logic [StoreWidth-1:0] first_ff  [CAPACITY];
   logic [StoreWidth-1:0] second_ff [CAPACITY];

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [VALUE_W-1:0]    rsp_first_ff;
   logic [VALUE_W-1:0]    rsp_second_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic                  rsp_last_ff;

   logic [CmpWidth-1:0]   count_ext;
   logic [CmpWidth-1:0]   pos_ext;
   logic [CmpWidth-1:0]   end_ext;
   logic [CmpWidth-1:0]   ins_ext;
   logic                  full;
   status_type            verdict;
   logic [IdxWidth-1:0]   head_idx;
   logic [CountWidth-1:0] count_up;
   logic [CountWidth-1:0] count_down;

   assign count_ext  = CmpWidth'(count_ff);
   assign pos_ext    = CmpWidth'(pos_ff);
   assign end_ext    = CmpWidth'(end_ff);
   assign full       = (count_ext >= CapLimit);
   assign ins_ext    = (op_ff == OP_APPEND) ? count_ext : pos_ext;
   assign head_idx   = pos_ext[IdxWidth-1:0];
   assign count_up   = count_ff + CountWidth'(1);
   assign count_down = count_ff - CountWidth'(1);

   always_comb begin
      case (op_ff)
         OP_APPEND: verdict = full ? STATUS_FULL : STATUS_DONE;
         OP_INSERT: begin
            if (full) begin
               verdict = STATUS_FULL;
            end else if (pos_ext > count_ext) begin
               verdict = STATUS_INVALID;
            end else begin
               verdict = STATUS_DONE;
            end
         end
         OP_REMOVE: begin
            if ((pos_ext > end_ext) || (end_ext >= count_ext)) begin
               verdict = STATUS_INVALID;
            end else begin
               verdict = STATUS_DONE;
            end
         end
         default: verdict = STATUS_INVALID;
      endcase
   end

   assign stat.verdict    = verdict;
   assign stat.remove_op  = (op_ff == OP_REMOVE);
   assign stat.final_step = (remain_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_opcode;
         first_in_ff  <= req_first_value[StoreWidth-1:0];
         second_in_ff <= req_second_value[StoreWidth-1:0];
         pos_ff       <= req_position;
         end_ff       <= req_range_end;
      end
      if (cmd.arm_remove) begin
         remain_ff <= end_ff - pos_ff;
      end else if (cmd.remove_step) begin
         remain_ff <= remain_ff - INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_up;
      end else if (cmd.remove_step) begin
         count_ff <= count_down;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
      localparam int Prev = (g > 0) ? g - 1 : 0;
      localparam int Next = (g < CAPACITY - 1) ? g + 1 : g;
      localparam logic [CmpWidth-1:0] Here = CmpWidth'(g);

      always_ff @(posedge clock) begin
         if (cmd.commit) begin
            if (Here == ins_ext) begin
               first_ff[g]  <= first_in_ff;
               second_ff[g] <= second_in_ff;
            end else if ((Here > ins_ext) && (Here <= count_ext)) begin
               first_ff[g]  <= first_ff[Prev];
               second_ff[g] <= second_ff[Prev];
            end
         end else if (cmd.remove_step) begin
            if (Here >= pos_ext) begin
               first_ff[g]  <= first_ff[Next];
               second_ff[g] <= second_ff[Next];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit | cmd.reject | cmd.remove_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit || cmd.reject) begin
         rsp_status_ff <= verdict;
         rsp_first_ff  <= '0;
         rsp_second_ff <= '0;
         rsp_total_ff  <= cmd.commit ? TOTAL_W'(count_up) : TOTAL_W'(count_ff);
         rsp_last_ff   <= 1'b1;
      end else if (cmd.remove_step) begin
         rsp_status_ff <= STATUS_DONE;
         rsp_first_ff  <= VALUE_W'(first_ff[head_idx]);
         rsp_second_ff <= VALUE_W'(second_ff[head_idx]);
         rsp_total_ff  <= TOTAL_W'(count_down - CountWidth'(remain_ff));
         rsp_last_ff   <= (remain_ff == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_removed_first  = rsp_first_ff;
   assign rsp_removed_second = rsp_second_ff;
   assign rsp_entry_total    = rsp_total_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/positional_pair_list.sv -----
// append, insert and rejected words: captured on the accept edge, judged in
// the decide state, one result word registered as the block returns to idle
// remove of n pairs: busy through n remove steps after the decide state, each
// shifting the array, one word per cycle from the shift array's head read port
// the receiver cannot stall; each result word is valid for one cycle only
// sync reset empties the list; stored pairs are not cleared and need no sweep
`default_nettype none

module positional_pair_list #(
   parameter int CAPACITY   = ppl_pkg::CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = ppl_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [ppl_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire logic [ppl_pkg::VALUE_W-1:0]   req_first_value,
   input  wire logic [ppl_pkg::VALUE_W-1:0]   req_second_value,
   input  wire logic [ppl_pkg::INDEX_W-1:0]   req_position,
   input  wire logic [ppl_pkg::INDEX_W-1:0]   req_range_end,
   output      logic                          rsp_valid,
   output      logic [ppl_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [ppl_pkg::VALUE_W-1:0]   rsp_removed_first,
   output      logic [ppl_pkg::VALUE_W-1:0]   rsp_removed_second,
   output      logic [ppl_pkg::TOTAL_W-1:0]   rsp_entry_total,
   output      logic                          rsp_last
);
   import ppl_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   ppl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ppl_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .req_position       (req_position),
      .req_range_end      (req_range_end),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_removed_first  (rsp_removed_first),
      .rsp_removed_second (rsp_removed_second),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

// ----- bench/positional_pair_list_tb.sv -----
// testbench for positional_pair_list: directed and random append, insert and
// remove-range words checked against a mirrored copy of the pair list
// depends on ppl_pkg and the positional_pair_list rtl

module positional_pair_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppl_pkg::*;

   localparam int CAPACITY       = CAPACITY_DEFAULT;
   localparam int RANDOM_WORDS   = 93;
   localparam int TIMEOUT_CYCLES = 60000;
   localparam int MAX_REPORTS    = 10;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      status_type           status;
      logic [VALUE_W-1:0]   first;
      logic [VALUE_W-1:0]   second;
      logic [TOTAL_W-1:0]   total;
      logic                 last;
   } reply_word_type;

   class list_mirror_type;
      logic [VALUE_W-1:0] first_store [CAPACITY];
      logic [VALUE_W-1:0] second_store [CAPACITY];
      int unsigned        held;
      reply_word_type     due_words [$];
      int unsigned        mismatches;

      function new();
         held       = 0;
         mismatches = 0;
      endfunction

      function void add_reply(status_type st, logic [VALUE_W-1:0] f,
                              logic [VALUE_W-1:0] s, logic lst);
         reply_word_type w;
         w.status = st;
         w.first  = f;
         w.second = s;
         w.total  = TOTAL_W'(held);
         w.last   = lst;
         due_words = {due_words, w};
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] a,
                                 logic [VALUE_W-1:0] b, logic [INDEX_W-1:0] pos,
                                 logic [INDEX_W-1:0] rend);
         logic [VALUE_W-1:0] cut_first [CAPACITY];
         logic [VALUE_W-1:0] cut_second [CAPACITY];
         int unsigned        span;
         case (op)
            OP_APPEND: begin
               if (held >= CAPACITY) begin
                  add_reply(STATUS_FULL, '0, '0, 1'b1);
               end else begin
                  first_store[held]  = a;
                  second_store[held] = b;
                  held++;
                  add_reply(STATUS_DONE, '0, '0, 1'b1);
               end
            end
            OP_INSERT: begin
               if (held >= CAPACITY) begin
                  add_reply(STATUS_FULL, '0, '0, 1'b1);
               end else if (pos > held) begin
                  add_reply(STATUS_INVALID, '0, '0, 1'b1);
               end else begin
                  for (int i = held; i > pos; i--) begin
                     first_store[i]  = first_store[i-1];
                     second_store[i] = second_store[i-1];
                  end
                  first_store[pos]  = a;
                  second_store[pos] = b;
                  held++;
                  add_reply(STATUS_DONE, '0, '0, 1'b1);
               end
            end
            OP_REMOVE: begin
               if (pos > rend || rend >= held) begin
                  add_reply(STATUS_INVALID, '0, '0, 1'b1);
               end else begin
                  span = rend - pos + 1;
                  for (int k = 0; k < span; k++) begin
                     cut_first[k]  = first_store[pos+k];
                     cut_second[k] = second_store[pos+k];
                  end
                  for (int i = rend + 1; i < held; i++) begin
                     first_store[i-span]  = first_store[i];
                     second_store[i-span] = second_store[i];
                  end
                  held -= span;
                  for (int k = 0; k < span; k++)
                     add_reply(STATUS_DONE, cut_first[k], cut_second[k], k == span - 1);
               end
            end
            default: add_reply(STATUS_INVALID, '0, '0, 1'b1);
         endcase
      endfunction

      function void check_reply(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] f,
                                logic [VALUE_W-1:0] s, logic [TOTAL_W-1:0] tot,
                                logic lst);
         reply_word_type w;
         if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected word: status %0d first %h second %h total %0d last %0b",
                        st, f, s, tot, lst);
            return;
         end
         w = due_words.pop_front();
         if (st !== w.status || f !== w.first || s !== w.second ||
             tot !== w.total || lst !== w.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch: expected status %0d first %h second %h total %0d last %0b",
                        w.status, w.first, w.second, w.total, w.last);
               $display("          actual   status %0d first %h second %h total %0d last %0b",
                        st, f, s, tot, lst);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [OPCODE_W-1:0]  req_opcode;
   logic [VALUE_W-1:0]   req_first_value;
   logic [VALUE_W-1:0]   req_second_value;
   logic [INDEX_W-1:0]   req_position;
   logic [INDEX_W-1:0]   req_range_end;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [VALUE_W-1:0]   rsp_removed_first;
   logic [VALUE_W-1:0]   rsp_removed_second;
   logic [TOTAL_W-1:0]   rsp_entry_total;
   logic                 rsp_last;

   list_mirror_type ledger;
   int unsigned     cycle_count;

   positional_pair_list dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .req_position       (req_position),
      .req_range_end      (req_range_end),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_removed_first  (rsp_removed_first),
      .rsp_removed_second (rsp_removed_second),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && start && !busy)
         ledger.note_request(req_opcode, req_first_value, req_second_value,
                             req_position, req_range_end);
      if (!reset && rsp_valid)
         ledger.check_reply(rsp_status, rsp_removed_first, rsp_removed_second,
                            rsp_entry_total, rsp_last);
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] a,
                            input logic [VALUE_W-1:0] b, input logic [INDEX_W-1:0] pos,
                            input logic [INDEX_W-1:0] rend, input bit may_idle);
      if (may_idle)
         while ($urandom_range(99) < 32) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start            <= 1'b1;
      req_opcode       <= op;
      req_first_value  <= a;
      req_second_value <= b;
      req_position     <= pos;
      req_range_end    <= rend;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   // mostly legal words sized to the current list, some pure noise
   task automatic random_word(input bit may_idle);
      logic [OPCODE_W-1:0] op;
      logic [INDEX_W-1:0]  pos;
      logic [INDEX_W-1:0]  rend;
      int unsigned         held;
      int unsigned         room;
      held = ledger.held;
      op   = OPCODE_W'($urandom_range(3));
      pos  = INDEX_W'($urandom_range(31));
      rend = INDEX_W'($urandom_range(31));
      if ($urandom_range(99) >= 8) begin
         if ($urandom_range(CAPACITY) >= held) begin
            if ($urandom_range(1)) begin
               op = OP_APPEND;
            end else begin
               op  = OP_INSERT;
               pos = INDEX_W'($urandom_range(held));
            end
         end else begin
            op   = OP_REMOVE;
            pos  = INDEX_W'($urandom_range(held - 1));
            room = held - 1 - pos;
            if ($urandom_range(9) == 0)
               rend = INDEX_W'(pos + $urandom_range(room));
            else
               rend = INDEX_W'(pos + $urandom_range(room < 2 ? room : 2));
         end
      end
      send_word(op, pick_value(), pick_value(), pos, rend, may_idle);
   endtask

   initial begin
      ledger           = new();
      reset            <= 1'b1;
      start            <= 1'b0;
      req_opcode       <= OP_APPEND;
      req_first_value  <= '0;
      req_second_value <= '0;
      req_position     <= '0;
      req_range_end    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_REMOVE, '0, '0, 5'd0, 5'd0, 1'b1);
      send_word(OP_APPEND, '0, '0, 5'd31, 5'd31, 1'b1);
      send_word(OP_APPEND, '1, '1, 5'd0, 5'd0, 1'b1);
      send_word(OP_INSERT, 32'h0000_0001, 32'h8000_0000, 5'd0, 5'd31, 1'b1);
      send_word(OP_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 5'd3, 5'd0, 1'b1);
      send_word(OP_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 5'd2, 5'd0, 1'b1);
      send_word(OP_INSERT, pick_value(), pick_value(), 5'd31, 5'd0, 1'b1);
      send_word(OP_INSERT, pick_value(), pick_value(), 5'd6, 5'd0, 1'b1);
      send_word(OP_REMOVE, pick_value(), pick_value(), 5'd3, 5'd1, 1'b1);
      send_word(OP_REMOVE, pick_value(), pick_value(), 5'd2, 5'd5, 1'b1);
      send_word(OP_REMOVE, pick_value(), pick_value(), 5'd1, 5'd1, 1'b1);
      send_word(OP_UNUSED, '1, '1, 5'd31, 5'd31, 1'b1);
      while (ledger.held < CAPACITY)
         send_word(OP_APPEND, pick_value(), pick_value(), INDEX_W'($urandom),
                   INDEX_W'($urandom), 1'b1);
      send_word(OP_APPEND, '1, '0, 5'd0, 5'd0, 1'b1);
      send_word(OP_INSERT, '0, '1, 5'd0, 5'd0, 1'b1);
      send_word(OP_REMOVE, '0, '0, 5'd0, 5'd15, 1'b1);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // drain the pipe completely before some words
         if (n == 30 || n == 80) begin
            start <= 1'b0;
            do @(posedge clock); while (ledger.due_words.size() != 0);
         end
         random_word(!(n >= 40 && n < 75));
      end
      start <= 1'b0;

      while (ledger.due_words.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.due_words.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
design/ppl_pkg.sv
design/ppl_ctrl.sv
design/ppl_datapath.sv
design/positional_pair_list.sv
bench/positional_pair_list_tb.sv
